// ===== rtl/ascii_command_line_decoder_top_macros.svh =====
// Assertion helpers for the file that checks its own logic.
`ifndef ASCII_COMMAND_LINE_DECODER_TOP_MACROS_SVH
`define ASCII_COMMAND_LINE_DECODER_TOP_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define LCD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define LCD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lcd_pkg.sv =====
`timescale 1ns / 1ps

package lcd_pkg;

    // Default sizes of the line store and of the key table.
    localparam int LINE_CAPACITY_DEF = 32;
    localparam int MAX_ENTRIES_DEF   = 16;

    // Fixed field widths.
    localparam int CHAR_W     = 8;
    localparam int ID_W       = 8;
    localparam int VALUE_W    = 63;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int COUNT_W    = 5;
    localparam int ENTRY_W    = 16;
    localparam int ENTRY_IW   = 4;
    localparam int TABLE_WORDS = 4;

    localparam logic [VALUE_W-1:0] VALUE_MAX = '1;

    // Characters with a meaning of their own.
    localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
    localparam logic [CHAR_W-1:0] CH_VT    = 8'd11;
    localparam logic [CHAR_W-1:0] CH_FF    = 8'd12;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'd43;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'd45;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'd57;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ITEM_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_0    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_1    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_2    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_3    = 3'd4;

    typedef struct packed {
        logic              clear;
        logic              feed;
        logic [CHAR_W-1:0] ch;
    } t_parse_ctl;

    typedef struct packed {
        logic               ok;
        logic [VALUE_W-1:0] value;
    } t_parse_stat;

    typedef struct packed {
        logic            done;
        logic            hit;
        logic [ID_W-1:0] id;
    } t_match_stat;

endpackage

// ===== rtl/ascii_command_line_decoder_top.sv =====
// Channel   Direction  Handshake                     Payload
// input     in         i_in_valid / o_in_ready       i_rx_byte, i_chunk_end
// result    out        o_out_valid / i_out_ready     o_action_id, o_action_value
// config    in         i_cfg_we (no wait)            i_cfg_idx, i_cfg_data
//
// An ordinary byte or a carriage return is taken while idle and leaves the block idle.
// A line feed closing a good line reads the n stored characters back through the
// single read port of the line memory, then the key matcher compares one table
// entry per cycle, at most MAX_ENTRIES; the input is not ready until it is done.
// Reset is synchronous and active low; no clearing pass follows it.
// A waiting result does not block the input; only a second result waits for it.
`timescale 1ns / 1ps
`include "ascii_command_line_decoder_top_macros.svh"

module ascii_command_line_decoder_top
    import lcd_pkg::*;
#(
    parameter int LINE_CAPACITY = LINE_CAPACITY_DEF,
    parameter int MAX_ENTRIES   = MAX_ENTRIES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [CHAR_W-1:0]     i_rx_byte,
    input  logic                  i_chunk_end,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [ID_W-1:0]       o_action_id,
    output logic [VALUE_W-1:0]    o_action_value,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW = $clog2(LINE_CAPACITY);
    localparam logic [AW-1:0] FILL_MAX = AW'(LINE_CAPACITY - 1);

    // Sequencer states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_MATCH = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    logic [2:0]         r_state, n_state;
    logic [AW-1:0]      r_fill, n_fill;
    logic               r_bad, n_bad;
    logic [AW-1:0]      r_ptr;
    logic               r_rvld;
    logic [AW-1:0]      r_rtag;
    logic [CHAR_W-1:0]  r_key;

    logic               r_out_vld;
    logic [ID_W-1:0]    r_out_id;
    logic [VALUE_W-1:0] r_out_value;

    logic               in_acc;
    logic               is_lf, is_cr;
    logic               line_good;
    logic               mem_we;
    logic               mem_re;
    logic [CHAR_W-1:0]  mem_rdata;
    logic               scan_last;
    logic               num_ok;
    logic               match_start;
    logic               out_load;
    logic               out_free;

    t_parse_ctl         parse_ctl;
    t_parse_stat        parse_stat;
    t_match_stat        match_stat;

    // The chunk marker carries no meaning for decoding and is not used.

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign is_lf      = (i_rx_byte == CH_LF);
    assign is_cr      = (i_rx_byte == CH_CR);
    assign line_good  = !r_bad && (r_fill != '0);

    // Bytes are stored only while idle and read only while scanning, so the
    // memory never sees a read and a write of the same entry together.
    assign mem_we = in_acc && !is_lf && !is_cr && !r_bad && (r_fill < FILL_MAX);
    assign mem_re = (r_state == S_SCAN) && (r_ptr < r_fill);

    // The first stored character is the key; the rest go to the number parser.
    assign scan_last = r_rvld && (r_rtag == r_fill - AW'(1));

    assign parse_ctl.clear = in_acc && is_lf;
    assign parse_ctl.feed  = r_rvld && (r_rtag != '0);
    assign parse_ctl.ch    = mem_rdata;

    // A line holding only the key carries the value zero.
    assign num_ok      = (r_fill == AW'(1)) || parse_stat.ok;
    assign match_start = (r_state == S_CHECK) && num_ok;

    assign out_free = !r_out_vld || i_out_ready;
    assign out_load = (r_state == S_EMIT) && match_stat.hit && out_free;

    always_comb begin
        n_state = r_state;
        n_fill  = r_fill;
        n_bad   = r_bad;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && !is_cr) begin
                    if (is_lf) begin
                        if (line_good) begin
                            n_state = S_SCAN;
                        end else begin
                            n_fill = '0;
                            n_bad  = 1'b0;
                        end
                    end else if (mem_we) begin
                        n_fill = r_fill + AW'(1);
                    end else begin
                        n_bad = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                if (scan_last) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_fill  = '0;
                n_state = num_ok ? S_MATCH : S_IDLE;
            end
            S_MATCH: begin
                if (match_stat.done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!match_stat.hit || out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fill    <= '0;
            r_bad     <= 1'b0;
            r_ptr     <= '0;
            r_rvld    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_bad   <= n_bad;
            r_rvld  <= mem_re;
            if (parse_ctl.clear) begin
                r_ptr <= '0;
            end else if (mem_re) begin
                r_ptr <= r_ptr + AW'(1);
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rtag <= r_ptr;
        end
        if (r_rvld && (r_rtag == '0)) begin
            r_key <= mem_rdata;
        end
        if (out_load) begin
            r_out_id    <= match_stat.id;
            r_out_value <= parse_stat.value;
        end
    end

    lcd_line_mem #(
        .LINE_CAPACITY (LINE_CAPACITY),
        .AW            (AW)
    ) u_line_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_fill),
        .i_wdata (i_rx_byte),
        .i_re    (mem_re),
        .i_raddr (r_ptr),
        .o_rdata (mem_rdata)
    );

    lcd_num_parse u_num_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (parse_ctl),
        .o_stat  (parse_stat)
    );

    lcd_key_match #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_key_match (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_start    (match_start),
        .i_key      (r_key),
        .o_stat     (match_stat)
    );

    assign o_out_valid    = r_out_vld;
    assign o_action_id    = r_out_id;
    assign o_action_value = r_out_value;

    // The stored line never grows past its capacity less one.
    `LCD_ASSERT_NOW(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= FILL_MAX, "line overfilled")
    // A line feed closing a good line always starts a scan of the memory.
    `LCD_ASSERT_NEXT(a_lf_scan, i_clk, i_rst_n, in_acc && is_lf && line_good, r_state == S_SCAN, "no scan after line feed")
    // Memory read data only ever arrives during a scan.
    `LCD_ASSERT_NOW(a_read_in_scan, i_clk, i_rst_n, r_rvld, r_state == S_SCAN, "stray memory read")
    // A new result only appears after the emit step with a table hit.
    `LCD_ASSERT_NOW(a_out_source, i_clk, i_rst_n, $rose(o_out_valid), $past(r_state) == S_EMIT, "result without a match")

endmodule

// ===== rtl/lcd_line_mem.sv =====
`timescale 1ns / 1ps

module lcd_line_mem
    import lcd_pkg::*;
#(
    parameter int LINE_CAPACITY = LINE_CAPACITY_DEF,
    parameter int AW            = $clog2(LINE_CAPACITY)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [CHAR_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr,
    output logic [CHAR_W-1:0] o_rdata
);

    logic [CHAR_W-1:0] r_mem [LINE_CAPACITY];
    logic [CHAR_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/lcd_num_parse.sv =====
`timescale 1ns / 1ps

module lcd_num_parse
    import lcd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_parse_ctl  i_ctl,
    output t_parse_stat o_stat
);

    // Parser phases.
    localparam logic [1:0] PH_LEAD   = 2'd0;
    localparam logic [1:0] PH_SIGN   = 2'd1;
    localparam logic [1:0] PH_DIGIT  = 2'd2;
    localparam logic [1:0] PH_REJECT = 2'd3;

    localparam int ACC_W = VALUE_W + 4;

    logic [1:0]         r_phase, n_phase;
    logic               r_neg, n_neg;
    logic [VALUE_W-1:0] r_acc, n_acc;

    logic               is_blank, is_sign, is_digit;
    logic [ACC_W-1:0]   wide;
    logic [VALUE_W-1:0] step_val;

    assign is_blank = (i_ctl.ch == CH_SPACE) || (i_ctl.ch == CH_TAB) ||
                      (i_ctl.ch == CH_VT) || (i_ctl.ch == CH_FF);
    assign is_sign  = (i_ctl.ch == CH_PLUS) || (i_ctl.ch == CH_MINUS);
    assign is_digit = (i_ctl.ch >= CH_ZERO) && (i_ctl.ch <= CH_NINE);

    // acc*10 + digit; the value saturates once it passes the largest result.
    assign wide = ACC_W'({r_acc, 3'b000}) + ACC_W'({r_acc, 1'b0}) + ACC_W'(i_ctl.ch[3:0]);
    assign step_val = (|wide[ACC_W-1:VALUE_W]) ? VALUE_MAX : wide[VALUE_W-1:0];

    always_comb begin
        n_phase = r_phase;
        n_neg   = r_neg;
        n_acc   = r_acc;
        if (i_ctl.clear) begin
            n_phase = PH_LEAD;
            n_neg   = 1'b0;
            n_acc   = '0;
        end else if (i_ctl.feed) begin
            unique case (r_phase)
                PH_LEAD: begin
                    if (is_blank) begin
                        n_phase = PH_LEAD;
                    end else if (is_sign) begin
                        n_neg   = (i_ctl.ch == CH_MINUS);
                        n_phase = PH_SIGN;
                    end else if (is_digit) begin
                        n_acc   = step_val;
                        n_phase = PH_DIGIT;
                    end else begin
                        n_phase = PH_REJECT;
                    end
                end
                PH_SIGN, PH_DIGIT: begin
                    if (is_digit) begin
                        n_acc   = step_val;
                        n_phase = PH_DIGIT;
                    end else begin
                        n_phase = PH_REJECT;
                    end
                end
                PH_REJECT: begin
                    n_phase = PH_REJECT;
                end
                default: begin
                    n_phase = PH_REJECT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LEAD;
            r_neg   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_neg   <= n_neg;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    // Only minus zero survives a minus sign.
    assign o_stat.ok    = (r_phase == PH_DIGIT) && !(r_neg && (r_acc != '0));
    assign o_stat.value = r_acc;

endmodule

// ===== rtl/lcd_key_match.sv =====
`timescale 1ns / 1ps

module lcd_key_match
    import lcd_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int KW          = $clog2(MAX_ENTRIES + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_start,
    input  logic [CHAR_W-1:0]     i_key,
    output t_match_stat           o_stat
);

    logic [COUNT_W-1:0]    r_item_count;
    logic [CFG_DATA_W-1:0] r_word [TABLE_WORDS];

    logic                  r_busy;
    logic [KW-1:0]         r_k;
    logic [CHAR_W-1:0]     r_key;
    logic                  r_done;
    logic                  r_hit;
    logic [ID_W-1:0]       r_id;

    logic [COUNT_W-1:0]    lim_full;
    logic [KW-1:0]         limit;
    logic [ENTRY_IW-1:0]   idx;
    logic [ENTRY_W-1:0]    entry;
    logic                  key_eq;

    // Counts beyond the table size search the whole table.
    assign lim_full = (r_item_count > COUNT_W'(MAX_ENTRIES)) ? COUNT_W'(MAX_ENTRIES)
                                                             : r_item_count;
    assign limit    = KW'(lim_full);

    assign idx    = ENTRY_IW'(r_k);
    assign entry  = r_word[idx[3:2]][idx[1:0]*ENTRY_W +: ENTRY_W];
    assign key_eq = (entry[CHAR_W-1:0] == r_key);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_count <= '0;
            for (int w = 0; w < TABLE_WORDS; w++) begin
                r_word[w] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ITEM_COUNT: r_item_count <= i_cfg_data[COUNT_W-1:0];
                REG_TABLE_0:    r_word[0]    <= i_cfg_data;
                REG_TABLE_1:    r_word[1]    <= i_cfg_data;
                REG_TABLE_2:    r_word[2]    <= i_cfg_data;
                REG_TABLE_3:    r_word[3]    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // One table entry is compared per cycle, in table order.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_hit  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (limit == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_hit  <= 1'b0;
                end else if (key_eq) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_hit  <= 1'b1;
                end else if (r_k + KW'(1) == limit) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_hit  <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_k   <= '0;
            r_key <= i_key;
        end else if (r_busy) begin
            r_k <= r_k + KW'(1);
            if (key_eq) begin
                r_id <= entry[ENTRY_W-1:CHAR_W];
            end
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.hit  = r_hit;
    assign o_stat.id   = r_id;

endmodule

// ===== sim/ascii_command_line_decoder_top_tb.sv =====
`timescale 1ns / 1ps

module ascii_command_line_decoder_top_tb;
    import lcd_pkg::*;

    // The block has no code for an unused register index, so the testbench names one.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd5;

    // This pause covers a line feed on a full line with a full table search, so it
    // covers a line feed that ends without a result.
    localparam int SETTLE_CYCLES = 64;

    // The receiver's long hold-off, and the watchdog limit. The limit is several
    // times the longest quiet stretch of a correct run: the hold-off, a full
    // line feed and the pause before a register write.
    localparam int STALL_CYCLES   = 600;
    localparam int WATCHDOG_LIMIT = 4000;

    localparam logic [63:0] VALUE_CEIL = {1'b0, VALUE_MAX};
    localparam logic [CHAR_W-1:0] BLANK_CHARS [4] = '{CH_SPACE, CH_TAB, CH_VT, CH_FF};

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [VALUE_W-1:0] value;
    } t_decoded_action;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_in_valid     = 1'b0;
    logic                  o_in_ready;
    logic [CHAR_W-1:0]     i_rx_byte      = '0;
    logic                  i_chunk_end    = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready    = 1'b0;
    logic [ID_W-1:0]       o_action_id;
    logic [VALUE_W-1:0]    o_action_value;
    logic                  i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx      = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;

    ascii_command_line_decoder_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_rx_byte      (i_rx_byte),
        .i_chunk_end    (i_chunk_end),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_action_id    (o_action_id),
        .o_action_value (o_action_value),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Shadow copy of the decoder: the line being assembled and the registers.
    logic [CHAR_W-1:0] line_chars [LINE_CAPACITY_DEF];
    int unsigned       line_len     = 0;
    bit                line_overrun = 1'b0;
    logic [COUNT_W-1:0] count_reg   = '0;
    logic [63:0]       table_regs [TABLE_WORDS] = '{default: '0};

    // Actions predicted but not yet seen at the output, oldest first.
    t_decoded_action expected_actions[$];

    int unsigned error_count = 0;
    int unsigned bytes_sent  = 0;
    int unsigned quiet_cycles = 0;

    // Idling controls. The sender's flag is only used by the stimulus process;
    // the receiver's flag and the hold-off request are read by the receiver at
    // the clock edge, so they are written with nonblocking assignments.
    bit          src_idle_on   = 1'b1;
    bit          sink_idle_on  = 1'b1;
    int unsigned stall_request = 0;
    int unsigned stall_served  = 0;
    int unsigned stall_left    = 0;

    // Decodes the characters after the key of the stored line. A zero return means
    // the line is rejected. Blanks may only come before the sign, at least one
    // digit is needed, nothing may follow the digits, and the value saturates.
    function automatic bit parse_line_value(output logic [VALUE_W-1:0] value);
        int unsigned p;
        bit          negative;
        bit          any_digit;
        logic [63:0] acc;
        logic [63:0] digit;
        p         = 1;
        negative  = 1'b0;
        any_digit = 1'b0;
        acc       = '0;
        value     = '0;
        while (p < line_len && (line_chars[p] == CH_SPACE || line_chars[p] == CH_TAB ||
                                line_chars[p] == CH_VT || line_chars[p] == CH_FF))
            p++;
        if (p < line_len && (line_chars[p] == CH_PLUS || line_chars[p] == CH_MINUS)) begin
            negative = (line_chars[p] == CH_MINUS);
            p++;
        end
        while (p < line_len && line_chars[p] >= CH_ZERO && line_chars[p] <= CH_NINE) begin
            digit = 64'(line_chars[p] - CH_ZERO);
            if (acc > (VALUE_CEIL - digit) / 10)
                acc = VALUE_CEIL;
            else
                acc = acc * 10 + digit;
            any_digit = 1'b1;
            p++;
        end
        if (!any_digit || p != line_len)
            return 1'b0;
        // A minus sign is only tolerated on a value of zero.
        if (negative && acc != 0)
            return 1'b0;
        value = acc[VALUE_W-1:0];
        return 1'b1;
    endfunction

    // Follows one accepted byte through the line assembly. A line feed on a good,
    // non-empty line whose key is in the searched part of the table queues one
    // expected action.
    task automatic track_rx_byte(input logic [CHAR_W-1:0] c);
        bit                 line_ok;
        bit                 found;
        logic [VALUE_W-1:0] value;
        logic [CHAR_W-1:0]  key;
        logic [ENTRY_W-1:0] entry;
        int unsigned        searched;
        int unsigned        k;
        if (c == CH_CR)
            return;
        if (c != CH_LF) begin
            // The store keeps one slot free; one byte too many spoils the line.
            if (!line_overrun && line_len < LINE_CAPACITY_DEF - 1) begin
                line_chars[line_len] = c;
                line_len++;
            end else begin
                line_overrun = 1'b1;
            end
            return;
        end
        line_ok = !line_overrun && line_len > 0;
        value   = '0;
        if (line_ok && line_len > 1)
            line_ok = parse_line_value(value);
        key = line_chars[0];
        if (line_ok) begin
            searched = (count_reg > MAX_ENTRIES_DEF) ? MAX_ENTRIES_DEF : count_reg;
            found    = 1'b0;
            for (k = 0; k < searched && !found; k++) begin
                entry = table_regs[k / 4][16 * (k % 4) +: 16];
                if (entry[7:0] == key) begin
                    expected_actions.push_back('{id: entry[15:8], value: value});
                    found = 1'b1;
                end
            end
        end
        line_len     = 0;
        line_overrun = 1'b0;
    endtask

    // Offers one byte, with a random gap before it while the sender idles, and
    // holds it until the block takes it.
    task automatic send_byte(input logic [CHAR_W-1:0] c);
        int unsigned gap;
        gap = 0;
        if (src_idle_on)
            while ($urandom_range(99) < 22 && gap < 8)
                gap++;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_rx_byte   <= c;
        i_chunk_end <= 1'($urandom_range(1));
        do
            @(posedge i_clk);
        while (!o_in_ready);
        track_rx_byte(c);
        if (c != CH_CR)
            bytes_sent++;
    endtask

    task automatic send_line(input string body);
        for (int i = 0; i < body.len(); i++)
            send_byte(body[i]);
        send_byte(CH_LF);
    endtask

    // Drops valid, waits for every expected action, then lets a line feed that
    // ends without a result finish its table search.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_actions.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            REG_ITEM_COUNT: count_reg = data[COUNT_W-1:0];
            REG_TABLE_0:    table_regs[0] = data;
            REG_TABLE_1:    table_regs[1] = data;
            REG_TABLE_2:    table_regs[2] = data;
            REG_TABLE_3:    table_regs[3] = data;
            default: ;
        endcase
    endtask

    // Writes the whole table, the entry count and one unused index, which the
    // block must ignore. Write enable stays high across the burst.
    task automatic program_decoder(input logic [63:0] count_data, input logic [63:0] w0,
                                   input logic [63:0] w1, input logic [63:0] w2,
                                   input logic [63:0] w3);
        write_register(REG_TABLE_0, w0);
        write_register(REG_TABLE_1, w1);
        write_register(REG_TABLE_2, w2);
        write_register(REG_TABLE_3, w3);
        write_register(REG_SPARE, {$urandom, $urandom});
        write_register(REG_ITEM_COUNT, count_data);
        i_cfg_we <= 1'b0;
    endtask

    // Fills the table with random ids and keys, half of them from a few letters
    // so that duplicate keys show that the first match wins.
    task automatic program_random_table(input logic [63:0] count_data);
        logic [63:0]       words [TABLE_WORDS];
        logic [CHAR_W-1:0] key;
        int unsigned       w;
        int unsigned       e;
        for (w = 0; w < TABLE_WORDS; w++)
            for (e = 0; e < 4; e++) begin
                key = $urandom_range(1) ? 8'($urandom_range(255)) : 8'("A" + $urandom_range(7));
                words[w][16 * e +: 16] = {8'($urandom_range(255)), key};
            end
        program_decoder(count_data, words[0], words[1], words[2], words[3]);
    endtask

    // Most lines are well formed: a key from the searched part of the table and a
    // number with random blanks, sign and digits. The rest are bare keys, text,
    // overlong lines, stray bytes without a line feed, and scattered returns.
    task automatic send_random_line();
        logic [CHAR_W-1:0] line_q[$];
        int unsigned       roll;
        int unsigned       shape;
        int unsigned       n;
        int unsigned       searched;
        int unsigned       k;
        bit                zeros_only;
        roll     = $urandom_range(99);
        searched = (count_reg > MAX_ENTRIES_DEF) ? MAX_ENTRIES_DEF : count_reg;
        if (roll < 8) begin
            n = $urandom_range(1, 8);
            repeat (n) line_q.push_back(8'($urandom_range(255)));
        end else begin
            if (searched != 0 && $urandom_range(3) != 0) begin
                k = $urandom_range(searched - 1);
                line_q.push_back(table_regs[k / 4][16 * (k % 4) +: 8]);
            end else begin
                line_q.push_back(8'($urandom_range(255)));
            end
            shape = $urandom_range(99);
            if (shape >= 15 && shape < 80) begin
                repeat ($urandom_range(2)) line_q.push_back(BLANK_CHARS[$urandom_range(3)]);
                case ($urandom_range(5))
                    0: line_q.push_back(CH_PLUS);
                    1: line_q.push_back(CH_MINUS);
                    default: ;
                endcase
                // Now and then enough digits to reach saturation.
                n = ($urandom_range(9) == 0) ? $urandom_range(15, 22) : $urandom_range(1, 6);
                zeros_only = ($urandom_range(3) == 0);
                repeat (n)
                    line_q.push_back(zeros_only ? CH_ZERO : 8'(CH_ZERO + $urandom_range(9)));
                if ($urandom_range(9) == 0)
                    line_q.push_back(8'($urandom_range(255)));
            end else if (shape >= 80 && shape < 90) begin
                repeat ($urandom_range(1, 5)) line_q.push_back(8'($urandom_range(255)));
            end else if (shape >= 90) begin
                repeat ($urandom_range(28, 40))
                    line_q.push_back(8'(CH_ZERO + $urandom_range(9)));
            end
            line_q.push_back(CH_LF);
        end
        foreach (line_q[i]) begin
            if ($urandom_range(19) == 0)
                send_byte(CH_CR);
            send_byte(line_q[i]);
        end
    endtask

    // Right after reset the entry count is zero, so nothing may match, not
    // even a key of zero against the cleared table.
    task automatic test_reset_table();
        send_line("A5");
        send_byte(8'h00);
        send_byte(CH_LF);
        wait_idle();
    endtask

    // Every special case of the line format, against a table whose first entries
    // hold the extreme ids and keys and whose last entry is reachable because
    // a count above the table size searches the whole table.
    task automatic test_directed_lines();
        program_decoder(64'hFFFF_FFFF_FFFF_FFFF,
                        64'h22FF_1100_FF42_0041, 64'h5551_5551_5551_3341,
                        64'h5551_5551_5551_5551, 64'h4443_5551_5551_5551);
        send_line("");
        send_line("A");
        send_line("A\015 7");
        send_line("B\011\013\014 +42");
        send_line("A-0");
        send_line("A-000");
        send_line("A-5");
        send_line("A12x");
        send_line("A+");
        send_line("A 5 ");
        send_line("A9223372036854775807");
        send_line("B99999999999999999999");
        send_line("A-99999999999999999999");
        send_line("Z1");
        send_line("C5");
        // A zero byte can be a key, but after a key it is plain text.
        send_byte(8'h00);
        send_byte("3");
        send_byte(CH_LF);
        send_byte("A");
        send_byte(8'h00);
        send_byte(CH_LF);
        send_byte(8'hFF);
        send_byte(CH_LF);
        // The longest good line, then one byte too many, then recovery.
        send_byte("A");
        repeat (LINE_CAPACITY_DEF - 3) send_byte(CH_ZERO);
        send_byte("1");
        send_byte(CH_LF);
        send_byte("B");
        repeat (LINE_CAPACITY_DEF - 1) send_byte("1");
        send_byte(CH_LF);
        send_line("A8");
        wait_idle();
    endtask

    // With only two entries searched, keys further down the table are invisible.
    task automatic test_entry_count_limit();
        write_register(REG_ITEM_COUNT, 64'd2);
        i_cfg_we <= 1'b0;
        send_line("A1");
        send_line("B2");
        send_line("C3");
        send_byte(8'h00);
        send_byte("4");
        send_byte(CH_LF);
        wait_idle();
    endtask

    // The receiver holds off for a long stretch while short matching lines keep
    // coming, so a result waits, the next one backs up and the input stalls.
    task automatic test_back_pressure();
        stall_request <= stall_request + 1;
        for (int i = 0; i < 16; i++)
            send_line($sformatf("A%0d", i));
        wait_idle();
    endtask

    // Random traffic over several table settings, the extremes among them. One
    // phase runs with neither side idling.
    task automatic test_random_traffic();
        int unsigned phase;
        int unsigned target;
        logic [63:0] count_data;
        for (phase = 0; phase < 6; phase++) begin
            case (phase)
                0: count_data = 64'd16;
                1: count_data = 64'd1;
                3: count_data = 64'd16;
                4: count_data = 64'd0;
                default: count_data = {$urandom, $urandom};
            endcase
            program_random_table(count_data);
            src_idle_on  = (phase != 3);
            sink_idle_on <= (phase != 3);
            target = bytes_sent + ((phase == 4) ? 60 : (phase == 3) ? 250 : 150);
            while (bytes_sent < target)
                send_random_line();
            wait_idle();
        end
    endtask

    // Receiver: a requested hold-off first, then random idling when enabled.
    always @(posedge i_clk) begin
        if (stall_request != stall_served) begin
            stall_served <= stall_request;
            stall_left   <= STALL_CYCLES;
            i_out_ready  <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if (sink_idle_on && $urandom_range(99) < 22) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Each accepted action is compared with the oldest prediction.
    always @(posedge i_clk) begin
        t_decoded_action want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_actions.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("%0t: unexpected action id %0d value %0d",
                             $realtime, o_action_id, o_action_value);
            end else begin
                want = expected_actions.pop_front();
                if (o_action_id !== want.id || o_action_value !== want.value) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("%0t: action expected id %0d value %0d, got id %0d value %0d",
                                 $realtime, want.id, want.value, o_action_id, o_action_value);
                end
            end
        end
    end

    // Ends the run when nothing moves for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_table();
        test_directed_lines();
        test_entry_count_limit();
        test_back_pressure();
        test_random_traffic();
        if (error_count == 0 && expected_actions.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
